// ----- hdl/utcl_pkg.sv -----
// utcl_pkg: shared constants and types for the utf8 text cursor layout unit
// no dependencies; imported by the decoder, the top level and the testbench
package utcl_pkg;

  // line step applied by a newline
  localparam int LINE_HEIGHT = 16;

  // input commands
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_TEXT  = 2'd2;

  // decoder stages
  localparam logic [1:0] DEC_LEAD   = 2'd0;
  localparam logic [1:0] DEC_SECOND = 2'd1;
  localparam logic [1:0] DEC_THIRD  = 2'd2;

  // operations handed to the layout stage
  localparam logic [1:0] OP_NONE    = 2'd0;
  localparam logic [1:0] OP_START   = 2'd1;
  localparam logic [1:0] OP_NEWLINE = 2'd2;
  localparam logic [1:0] OP_PLACE   = 2'd3;

  // special runes and pen steps
  localparam logic [15:0] SUBST_RUNE   = 16'h003F;
  localparam logic [15:0] NEWLINE_RUNE = 16'h000A;
  localparam logic [15:0] NARROW_STEP  = 16'd8;
  localparam logic [15:0] WIDE_STEP    = 16'd16;

  // attribute bits
  localparam int ATTR_PRESENT = 0;
  localparam int ATTR_WIDE    = 1;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] rune;
  } dec_out_t;

endpackage

// ----- hdl/utcl_if.sv -----
// utcl_if: valid/ready channel interfaces for command input and layout results
// no dependencies
interface utcl_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic [7:0]         byte_value;
  logic [15:0]        code_point;
  logic               glyph_present;
  logic               glyph_wide;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;

  modport source (
    output valid, command, byte_value, code_point, glyph_present, glyph_wide,
           start_x, start_y,
    input  ready
  );
  modport sink (
    input  valid, command, byte_value, code_point, glyph_present, glyph_wide,
           start_x, start_y,
    output ready
  );
endinterface

interface utcl_out_if;
  logic               valid;
  logic               ready;
  logic [15:0]        rune;
  logic signed [15:0] pen_x;
  logic signed [15:0] pen_y;
  logic               wide;
  logic               substituted;

  modport source (
    output valid, rune, pen_x, pen_y, wide, substituted,
    input  ready
  );
  modport sink (
    input  valid, rune, pen_x, pen_y, wide, substituted,
    output ready
  );
endinterface

// ----- hdl/utcl_decoder.sv -----
// utcl_decoder: utf8 decoder for one to three byte sequences with halt on bad input
// depends on utcl_pkg
module utcl_decoder
  import utcl_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [1:0] command,
  input  logic [7:0] byte_value,
  output dec_out_t   dec
);

  logic [1:0] stage;
  logic [1:0] stage_next;
  logic [7:0] lead_byte;
  logic [7:0] lead_next;
  logic [7:0] second_byte;
  logic [7:0] second_next;
  logic       halted;
  logic       halted_next;
  logic       emit;
  logic [15:0] rune;

  // decode one byte against the current stage
  always_comb begin
    stage_next  = stage;
    lead_next   = lead_byte;
    second_next = second_byte;
    halted_next = halted;
    emit        = 1'b0;
    rune        = 16'd0;
    dec.op      = OP_NONE;
    if (command == CMD_START) begin
      stage_next  = DEC_LEAD;
      halted_next = 1'b0;
      dec.op      = OP_START;
    end else if (command == CMD_TEXT && !halted) begin
      if (byte_value == 8'h00) begin
        halted_next = 1'b1;
      end else begin
        case (stage)
          DEC_LEAD: begin
            if (!byte_value[7]) begin
              emit = 1'b1;
              rune = {8'h00, byte_value};
            end else if (byte_value[7:5] == 3'b110 || byte_value[7:4] == 4'b1110) begin
              lead_next  = byte_value;
              stage_next = DEC_SECOND;
            end else begin
              halted_next = 1'b1;
            end
          end
          DEC_SECOND: begin
            if (lead_byte[7:5] == 3'b110) begin
              stage_next = DEC_LEAD;
              emit       = 1'b1;
              rune       = {5'd0, lead_byte[4:0], byte_value[5:0]};
            end else begin
              second_next = byte_value;
              stage_next  = DEC_THIRD;
            end
          end
          default: begin
            stage_next = DEC_LEAD;
            emit       = 1'b1;
            rune       = {lead_byte[3:0], second_byte[5:0], byte_value[5:0]};
          end
        endcase
      end
    end
    if (emit) begin
      dec.op = (rune == NEWLINE_RUNE) ? OP_NEWLINE : OP_PLACE;
    end
    dec.rune = rune;
  end

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      stage       <= DEC_LEAD;
      lead_byte   <= 8'd0;
      second_byte <= 8'd0;
      halted      <= 1'b1;
    end else if (fire) begin
      stage       <= stage_next;
      lead_byte   <= lead_next;
      second_byte <= second_next;
      halted      <= halted_next;
    end
  end

endmodule

// ----- hdl/utf8_text_cursor_layout_unit.sv -----
// utf8_text_cursor_layout_unit: utf8 text layout front end with a glyph attribute memory
// depends on utcl_pkg, utcl_if and utcl_decoder
// after its last byte is accepted, a rune goes through the layout stage and output registers
// throughput: one input transfer per cycle unless a full output stage holds the layout stage
// the '?' attribute is shadowed in a register, so each rune costs one memory read
// reset clears decoder, pen and pipeline control; decoder starts halted; memory is not cleared
module utf8_text_cursor_layout_unit
  import utcl_pkg::*;
(
  input logic clk,
  input logic rst,
  utcl_in_if.sink    in_ch,
  utcl_out_if.source out_ch
);

  logic        in_fire;
  dec_out_t    dec;

  logic [1:0]  attr_mem [0:65535];
  logic [1:0]  rd_attr;
  logic [1:0]  qmark_attr;

  logic        s1_valid;
  logic [1:0]  s1_op;
  logic [15:0] s1_rune;
  logic [15:0] s1_x;
  logic [15:0] s1_y;
  logic [1:0]  s1_qattr;
  logic        s1_adv;

  logic [15:0] cursor_x;
  logic [15:0] cursor_y;
  logic [15:0] left_margin;

  logic        out_valid;
  logic        place_subst;
  logic        place_wide;
  logic [15:0] place_rune;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign s1_adv       = s1_valid && (s1_op != OP_PLACE || !out_valid || out_ch.ready);
  assign in_ch.ready  = !s1_valid || s1_adv;

  utcl_decoder u_decoder (
    .clk        (clk),
    .rst        (rst),
    .fire       (in_fire),
    .command    (in_ch.command),
    .byte_value (in_ch.byte_value),
    .dec        (dec)
  );

  // attribute memory: loads write, every transfer reads the decoded rune
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.command == CMD_LOAD) begin
      attr_mem[in_ch.code_point] <= {in_ch.glyph_wide, in_ch.glyph_present};
    end
    if (in_fire) begin
      rd_attr <= attr_mem[dec.rune];
    end
  end

  // shadow copy of the '?' entry for substitution
  always_ff @(posedge clk) begin
    if (in_fire && in_ch.command == CMD_LOAD && in_ch.code_point == SUBST_RUNE) begin
      qmark_attr <= {in_ch.glyph_wide, in_ch.glyph_present};
    end
  end

  // layout stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= (dec.op != OP_NONE);
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // layout stage payload
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_op    <= dec.op;
      s1_rune  <= dec.rune;
      s1_x     <= in_ch.start_x;
      s1_y     <= in_ch.start_y;
      s1_qattr <= qmark_attr;
    end
  end

  // glyph substitution
  always_comb begin
    place_subst = !rd_attr[ATTR_PRESENT];
    place_rune  = place_subst ? SUBST_RUNE : s1_rune;
    place_wide  = place_subst ? s1_qattr[ATTR_WIDE] : rd_attr[ATTR_WIDE];
  end

  // pen state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x    <= 16'd0;
      cursor_y    <= 16'd0;
      left_margin <= 16'd0;
    end else if (s1_adv) begin
      case (s1_op)
        OP_START: begin
          cursor_x    <= s1_x;
          left_margin <= s1_x;
          cursor_y    <= s1_y;
        end
        OP_NEWLINE: begin
          cursor_x <= left_margin;
          cursor_y <= cursor_y + 16'(LINE_HEIGHT);
        end
        OP_PLACE: begin
          cursor_x <= cursor_x + (place_wide ? WIDE_STEP : NARROW_STEP);
        end
        default: begin
          cursor_x <= cursor_x;
        end
      endcase
    end
  end

  // output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv && s1_op == OP_PLACE) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (s1_adv && s1_op == OP_PLACE) begin
      out_ch.rune        <= place_rune;
      out_ch.pen_x       <= $signed(cursor_x);
      out_ch.pen_y       <= $signed(cursor_y);
      out_ch.wide        <= place_wide;
      out_ch.substituted <= place_subst;
    end
  end

  assign out_ch.valid = out_valid;

endmodule

// ----- verif/utf8_text_cursor_layout_unit_tb.sv -----
`timescale 1ns / 1ps
// utf8_text_cursor_layout_unit_tb: self-checking bench for the utf8 text layout unit
// depends on utcl_pkg, utcl_if and the utf8_text_cursor_layout_unit rtl
// a tracker class predicts every placed glyph; random idles on both channels
module utf8_text_cursor_layout_unit_tb
  import utcl_pkg::*;
();

  // command code the block ignores
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [7:0]  byte_value;
    logic [15:0] code_point;
    logic        glyph_present;
    logic        glyph_wide;
    logic [15:0] start_x;
    logic [15:0] start_y;
  } text_cmd_t;

  typedef struct packed {
    logic [15:0] rune;
    logic [15:0] pen_x;
    logic [15:0] pen_y;
    logic        wide;
    logic        substituted;
  } glyph_t;

  // pen and decoder tracker with the queue of glyphs still to come out
  class glyph_layout_tracker;
    bit [1:0]    attr_mem [0:65535];
    bit          written [0:65535];
    logic [15:0] written_list[$];
    logic [15:0] pen_x, pen_y, margin;
    logic [1:0]  stage;
    logic [7:0]  lead, second;
    bit          halted;
    glyph_t      pending_glyphs[$];
    int          errors;

    function new();
      pen_x = '0;
      pen_y = '0;
      margin = '0;
      stage = DEC_LEAD;
      lead = '0;
      second = '0;
      halted = 1'b1;
      errors = 0;
    endfunction

    // tells whether text byte b would finish a rune, and which one
    function bit completes_rune(logic [7:0] b, output logic [15:0] r);
      r = '0;
      if (halted || b == 8'h00) return 1'b0;
      case (stage)
        DEC_LEAD: begin
          r = {8'h00, b};
          return !b[7];
        end
        DEC_SECOND: begin
          r = {5'b0, lead[4:0], b[5:0]};
          return lead[7:5] == 3'b110;
        end
        default: begin
          r = {lead[3:0], second[5:0], b[5:0]};
          return 1'b1;
        end
      endcase
    endfunction

    // newline moves the pen; any other rune queues a glyph and advances
    function void place_glyph(logic [15:0] r);
      glyph_t     g;
      logic [1:0] a;
      if (r == NEWLINE_RUNE) begin
        pen_x = margin;
        pen_y = pen_y + 16'(LINE_HEIGHT);
        return;
      end
      a = attr_mem[r];
      g.rune = r;
      g.substituted = 1'b0;
      if (!a[ATTR_PRESENT]) begin
        g.rune = SUBST_RUNE;
        g.substituted = 1'b1;
        a = attr_mem[SUBST_RUNE];
      end
      g.pen_x = pen_x;
      g.pen_y = pen_y;
      g.wide = a[ATTR_WIDE];
      pending_glyphs.push_back(g);
      pen_x = pen_x + (a[ATTR_WIDE] ? WIDE_STEP : NARROW_STEP);
    endfunction

    // notes an accepted command; returns 0 when the block ignores it
    function bit accept_command(text_cmd_t c);
      logic [15:0] r;
      case (c.command)
        CMD_LOAD: begin
          attr_mem[c.code_point] = {c.glyph_wide, c.glyph_present};
          if (!written[c.code_point]) begin
            written[c.code_point] = 1'b1;
            written_list.push_back(c.code_point);
          end
          return 1'b1;
        end
        CMD_START: begin
          pen_x = c.start_x;
          margin = c.start_x;
          pen_y = c.start_y;
          stage = DEC_LEAD;
          halted = 1'b0;
          return 1'b1;
        end
        CMD_TEXT: begin
          if (halted) return 1'b0;
          if (c.byte_value == 8'h00) begin
            halted = 1'b1;
          end else if (completes_rune(c.byte_value, r)) begin
            stage = DEC_LEAD;
            place_glyph(r);
          end else if (stage == DEC_LEAD) begin
            if (c.byte_value[7:5] == 3'b110 || c.byte_value[7:4] == 4'b1110) begin
              lead = c.byte_value;
              stage = DEC_SECOND;
            end else begin
              halted = 1'b1;
            end
          end else begin
            second = c.byte_value;
            stage = DEC_THIRD;
          end
          return 1'b1;
        end
        default: return 1'b0;
      endcase
    endfunction

    // compares one output transfer with the oldest queued glyph
    function void check_glyph(glyph_t got);
      glyph_t want;
      if (pending_glyphs.size() == 0) begin
        $display("%0t: unexpected glyph rune %h at (%0d,%0d)", $time, got.rune,
                 $signed(got.pen_x), $signed(got.pen_y));
        errors++;
        return;
      end
      want = pending_glyphs.pop_front();
      if (got.rune !== want.rune) begin
        $display("%0t: rune mismatch: expected %h, actual %h", $time, want.rune, got.rune);
        errors++;
      end
      if (got.pen_x !== want.pen_x) begin
        $display("%0t: pen_x mismatch: expected %0d, actual %0d", $time,
                 $signed(want.pen_x), $signed(got.pen_x));
        errors++;
      end
      if (got.pen_y !== want.pen_y) begin
        $display("%0t: pen_y mismatch: expected %0d, actual %0d", $time,
                 $signed(want.pen_y), $signed(got.pen_y));
        errors++;
      end
      if (got.wide !== want.wide) begin
        $display("%0t: wide mismatch: expected %b, actual %b", $time, want.wide, got.wide);
        errors++;
      end
      if (got.substituted !== want.substituted) begin
        $display("%0t: substituted mismatch: expected %b, actual %b", $time,
                 want.substituted, got.substituted);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  utcl_in_if  in_ch();
  utcl_out_if out_ch();

  glyph_layout_tracker tracker = new();
  int accepted_items = 0;
  bit burst_mode = 1'b0;

  utf8_text_cursor_layout_unit dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // fills every field at random; callers override what matters
  function automatic text_cmd_t random_fields();
    text_cmd_t c;
    c.command = CMD_TEXT;
    c.byte_value = 8'($urandom);
    c.code_point = 16'($urandom);
    c.glyph_present = 1'($urandom);
    c.glyph_wide = 1'($urandom);
    c.start_x = 16'($urandom);
    c.start_y = 16'($urandom);
    return c;
  endfunction

  // pen coordinates biased toward the 16-bit wrap points
  function automatic logic [15:0] pick_coord();
    case ($urandom_range(0, 3))
      0: return 16'h7FF0 + 16'($urandom_range(0, 15));
      1: return 16'hFFE0 + 16'($urandom_range(0, 31));
      default: return 16'($urandom);
    endcase
  endfunction

  // continuation byte; its top bits are not checked by the decoder
  function automatic logic [7:0] cont_byte(logic [5:0] v);
    logic [7:0] b;
    b = {($urandom_range(0, 3) == 0) ? 2'($urandom) : 2'b10, v};
    return (b == 8'h00) ? 8'h80 : b;
  endfunction

  // one input transfer after a random idle, with no idle in burst mode
  task automatic transfer(input text_cmd_t c);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.command <= c.command;
    in_ch.byte_value <= c.byte_value;
    in_ch.code_point <= c.code_point;
    in_ch.glyph_present <= c.glyph_present;
    in_ch.glyph_wide <= c.glyph_wide;
    in_ch.start_x <= c.start_x;
    in_ch.start_y <= c.start_y;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (tracker.accept_command(c)) accepted_items++;
  endtask

  task automatic load_attr(input logic [15:0] cp, input logic present, input logic wide);
    text_cmd_t c;
    c = random_fields();
    c.command = CMD_LOAD;
    c.code_point = cp;
    c.glyph_present = present;
    c.glyph_wide = wide;
    transfer(c);
  endtask

  task automatic start_at(input logic [15:0] x, input logic [15:0] y);
    text_cmd_t c;
    c = random_fields();
    c.command = CMD_START;
    c.start_x = x;
    c.start_y = y;
    transfer(c);
  endtask

  task automatic send_unused();
    text_cmd_t c;
    c = random_fields();
    c.command = CMD_UNUSED;
    transfer(c);
  endtask

  // text byte; loads any table entry the finished rune would read first
  task automatic send_text(input logic [7:0] b);
    logic [15:0] r;
    text_cmd_t   c;
    if (tracker.completes_rune(b, r) && r != NEWLINE_RUNE) begin
      if (!tracker.written[r])
        load_attr(r, $urandom_range(0, 3) != 0, 1'($urandom));
      if (!tracker.attr_mem[r][ATTR_PRESENT] && !tracker.written[SUBST_RUNE])
        load_attr(SUBST_RUNE, 1'($urandom), 1'($urandom));
    end
    c = random_fields();
    c.byte_value = b;
    transfer(c);
  endtask

  // utf-8 encoding of r, shortest form or now and then overlong
  task automatic send_rune(input logic [15:0] r);
    int len;
    if (r == 16'h0000) len = 2;
    else if (r < 16'h0080) len = 1;
    else if (r < 16'h0800) len = 2;
    else len = 3;
    if ($urandom_range(0, 5) == 0) len = $urandom_range(len, 3);
    case (len)
      1: send_text(r[7:0]);
      2: begin
        send_text({3'b110, r[10:6]});
        send_text(cont_byte(r[5:0]));
      end
      default: begin
        send_text({4'b1110, r[15:12]});
        send_text(cont_byte(r[11:6]));
        send_text(cont_byte(r[5:0]));
      end
    endcase
  endtask

  // result side: random stalls plus two long hold-offs
  initial begin : result_sink
    glyph_t got;
    int     stall;
    int     received;
    received = 0;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (received == 60 || received == 420) stall = 180;
      else stall = burst_mode ? 0 : $urandom_range(0, 10);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got.rune = out_ch.rune;
      got.pen_x = out_ch.pen_x;
      got.pen_y = out_ch.pen_y;
      got.wide = out_ch.wide;
      got.substituted = out_ch.substituted;
      tracker.check_glyph(got);
      received++;
    end
  end

  // stimulus: directed cases, then random traffic
  initial begin : stimulus
    int          pick;
    int          sel;
    logic [15:0] r;
    rst <= 1'b1;
    in_ch.valid <= 1'b0;
    in_ch.command <= CMD_LOAD;
    in_ch.byte_value <= '0;
    in_ch.code_point <= '0;
    in_ch.glyph_present <= 1'b0;
    in_ch.glyph_wide <= 1'b0;
    in_ch.start_x <= '0;
    in_ch.start_y <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // text before any start is dropped
    send_text("A");
    load_attr(SUBST_RUNE, 1'b1, 1'b1);
    load_attr(16'hFFFF, 1'b1, 1'b1);
    load_attr(16'h0000, 1'b0, 1'b0);
    // pen wraps past the top of the 16-bit range
    start_at(16'h7FF8, 16'h8000);
    send_text(8'h7F);
    send_rune(16'hFFFF);
    // overlong zero rune, missing glyph
    send_text(8'hE0);
    send_text(8'h80);
    send_text(8'h80);
    // overlong newline
    send_text(8'hC0);
    send_text(8'h8A);
    // continuation with top bits clear is taken as is
    send_text(8'hDF);
    send_text(8'h3F);
    // nul inside a sequence halts, then text is dropped
    send_text(8'hC2);
    send_text(8'h00);
    send_text("B");
    // bad leads: continuation byte, four-byte lead, 0xff
    start_at(16'h8000, 16'h7FFF);
    send_text(8'h80);
    start_at(16'h0000, 16'hFFF8);
    send_text(8'hF0);
    start_at(16'hFFF8, 16'h7FF8);
    send_text(8'hFF);
    // truncated sequence cut off by a start
    start_at(16'h0010, 16'h7FF8);
    send_text(8'hE2);
    send_text(8'h82);
    start_at(16'hFFF8, 16'h7FF8);
    send_unused();
    send_text("Z");
    send_text(8'h0A);

    // random traffic, mostly well-formed runes
    while (accepted_items < 950) begin
      if ($urandom_range(0, 39) == 0) burst_mode = !burst_mode;
      pick = $urandom_range(0, 99);
      if (pick < 6) begin
        start_at(pick_coord(), pick_coord());
      end else if (pick < 16) begin
        sel = $urandom_range(0, 7);
        if (sel == 0) r = SUBST_RUNE;
        else if (sel < 3 && tracker.written_list.size() > 0)
          r = tracker.written_list[$urandom_range(0, tracker.written_list.size() - 1)];
        else r = 16'($urandom);
        load_attr(r, $urandom_range(0, 3) != 0, 1'($urandom));
      end else if (pick < 84) begin
        if (tracker.halted) begin
          if ($urandom_range(0, 3) == 0) send_text(8'($urandom_range(1, 255)));
          start_at(pick_coord(), pick_coord());
        end
        sel = $urandom_range(0, 99);
        if (sel < 12) r = NEWLINE_RUNE;
        else if (sel < 45 && tracker.written_list.size() > 0)
          r = tracker.written_list[$urandom_range(0, tracker.written_list.size() - 1)];
        else if (sel < 65) r = 16'($urandom_range(1, 127));
        else if (sel < 80) r = 16'($urandom_range(128, 2047));
        else r = 16'($urandom);
        send_rune(r);
      end else begin
        case ($urandom_range(0, 4))
          0: send_text(8'($urandom));
          1: send_text(8'h00);
          2: send_text(($urandom_range(0, 1) == 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                   : 8'($urandom_range(8'hF0, 8'hFF)));
          3: begin
            if ($urandom_range(0, 1) == 1) begin
              send_text({3'b110, 5'($urandom)});
            end else begin
              send_text({4'b1110, 4'($urandom)});
              if ($urandom_range(0, 1) == 1) send_text(cont_byte(6'($urandom)));
            end
            start_at(pick_coord(), pick_coord());
          end
          default: send_unused();
        endcase
      end
    end

    // drain the pipeline, then report
    in_ch.valid <= 1'b0;
    while (tracker.pending_glyphs.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/utcl_pkg.sv
hdl/utcl_if.sv
hdl/utcl_decoder.sv
hdl/utf8_text_cursor_layout_unit.sv
verif/utf8_text_cursor_layout_unit_tb.sv
